### design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### design/pres_pkg.sv
`timescale 1ns / 1ps
package pres_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned InWidth  = 350;
  localparam int unsigned InBytes  = 352;
  localparam int unsigned OutWidth = 192;
  localparam int unsigned OutBytes = 192;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 48;

  typedef enum logic [1:0] {
    RegEmitterX = 2'd0,
    RegEmitterY = 2'd1,
    RegTimeStep = 2'd2,
    RegNone     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        age_in;
    logic [30:0]        lifespan;
    logic signed [31:0] angle_in;
    logic signed [31:0] spin_rate;
    logic signed [31:0] gravity_acc;
    logic signed [31:0] radial_acc;
    logic signed [31:0] tangent_acc;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

### design/particle_radial_euler_step_core.sv
`timescale 1ns / 1ps
// particle euler step core
// s_axis carries one particle item per transfer, m_axis one updated item.
// tdata fields are packed from bit 0 in the order of the port comments.
// configuration: cfg_we_i writes emitter x (0), emitter y (1), time step (2)
// at any clock edge; write only while no items are in flight.
// 89 register stages: 1 normalize, 32 square root, 48 divide,
// 1 sign, 6 integrate, 1 output register; an accepted item reaches
// m_axis_tvalid through all of them. the square root and divider are
// unrolled one step per stage, so one item is accepted every cycle unless
// the output stalls. throughput: one item per cycle while not stalled.
// the whole pipeline advances together; a stalled output register holds its
// item and stops the pipe, so s_axis_tready drops only while the output is
// full and not taken.
// reset clears all valid bits and the configuration registers to zero.
module particle_radial_euler_step_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, age_in, lifespan, angle_in, spin_rate,
  // gravity_acc, radial_acc, tangent_acc
  input  logic [pres_pkg::InBytes-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_age, new_angle, expired
  output logic [pres_pkg::OutBytes-1:0] m_axis_tdata
);
  logic signed [31:0] emx_q, emy_q;
  logic [19:0]        dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emx_q <= '0;
      emy_q <= '0;
      dt_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (pres_pkg::reg_idx_e'(cfg_idx_i))
        pres_pkg::RegEmitterX: emx_q <= cfg_data_i;
        pres_pkg::RegEmitterY: emy_q <= cfg_data_i;
        pres_pkg::RegTimeStep: dt_q  <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  pres_pkg::item_t itm;
  always_comb begin
    itm.pos_x       = s_axis_tdata[31:0];
    itm.pos_y       = s_axis_tdata[63:32];
    itm.vel_x       = s_axis_tdata[95:64];
    itm.vel_y       = s_axis_tdata[127:96];
    itm.age_in      = s_axis_tdata[158:128];
    itm.lifespan    = s_axis_tdata[189:159];
    itm.angle_in    = s_axis_tdata[221:190];
    itm.spin_rate   = s_axis_tdata[253:222];
    itm.gravity_acc = s_axis_tdata[285:254];
    itm.radial_acc  = s_axis_tdata[317:286];
    itm.tangent_acc = s_axis_tdata[349:318];
  end

  logic out_vld_q, en;
  logic [pres_pkg::OutBytes-1:0] out_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [32:0] dx, dy;
  assign dx = 33'(itm.pos_x) - 33'(emx_q);
  assign dy = 33'(itm.pos_y) - 33'(emy_q);

  logic               uv_vld, in_vld;
  logic signed [31:0] ux, uy;
  pres_pkg::item_t    uv_itm;
  logic [pres_pkg::OutBytes-1:0] res;

  assign in_vld = s_axis_tvalid && en;

  pres_unit_vec u_uv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_vld),
    .dx_i(dx), .dy_i(dy), .item_i(itm),
    .valid_o(uv_vld), .ux_o(ux), .uy_o(uy), .item_o(uv_itm)
  );

  logic int_vld;
  pres_integrate u_int (
    .clk_i, .rst_ni, .en_i(en), .valid_i(uv_vld),
    .ux_i(ux), .uy_i(uy), .item_i(uv_itm), .dt_i(dt_q),
    .valid_o(int_vld), .data_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= int_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
endmodule

### design/pres_sqrt_stage.sv
`timescale 1ns / 1ps
// one restoring step of integer square root
module pres_sqrt_stage (
  input  logic [63:0] n_i,
  input  logic [63:0] res_i,
  input  logic [63:0] bit_i,
  output logic [63:0] n_o,
  output logic [63:0] res_o
);
  logic [64:0] trial;
  always_comb begin
    trial = {1'b0, res_i} + {1'b0, bit_i};
    if ({1'b0, n_i} >= trial) begin
      n_o   = n_i - trial[63:0];
      res_o = (res_i >> 1) + bit_i;
    end else begin
      n_o   = n_i;
      res_o = res_i >> 1;
    end
  end
endmodule

### design/pres_div_stage.sv
`timescale 1ns / 1ps
// one restoring division step: shift in a dividend bit, subtract divisor
module pres_div_stage (
  input  logic [31:0] rem_i,
  input  logic        din_i,
  input  logic [31:0] den_i,
  output logic [31:0] rem_o,
  output logic        q_o
);
  logic [32:0] sh;
  always_comb begin
    sh = {rem_i, din_i};
    if (sh >= {1'b0, den_i}) begin
      rem_o = 32'(sh - {1'b0, den_i});
      q_o   = 1'b1;
    end else begin
      rem_o = sh[31:0];
      q_o   = 1'b0;
    end
  end
endmodule

### design/pres_unit_vec.sv
`timescale 1ns / 1ps
// pipelined unit vector: normalize, sqrt one step per stage, divide one bit
// per stage for both components; side payload travels with the valid bit
module pres_unit_vec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [32:0] dx_i,
  input  logic signed [32:0] dy_i,
  input  pres_pkg::item_t    item_i,
  output logic               valid_o,
  output logic signed [31:0] ux_o,
  output logic signed [31:0] uy_o,
  output pres_pkg::item_t    item_o
);
  localparam int unsigned NS = pres_pkg::SqrtSteps;
  localparam int unsigned ND = pres_pkg::DivSteps;
  localparam int unsigned L  = NS + ND + 2;

  logic [L-1:0]            vld_q;
  pres_pkg::item_t         itm_q [L];
  logic [L-1:0]            sx_q, sy_q, zero_q;

  // normalize stage
  logic [32:0] ax, ay, m;
  logic [31:0] nx_d, ny_d, mn;
  logic [4:0]  lz;
  logic [31:0] nx_q, ny_q;
  always_comb begin
    ax = dx_i[32] ? 33'(-dx_i) : 33'(dx_i);
    ay = dy_i[32] ? 33'(-dy_i) : 33'(dy_i);
    m  = (ax > ay) ? ax : ay;
    if (m[32] || m[31]) begin
      nx_d = ax[32:1];
      ny_d = ay[32:1];
    end else begin
      nx_d = ax[31:0];
      ny_d = ay[31:0];
    end
    mn = (nx_d > ny_d) ? nx_d : ny_d;
    lz = '0;
    for (int i = 0; i < 31; i++) begin
      if (mn[i]) lz = 5'(30 - i);
    end
    if (mn == '0) lz = '0;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q <= nx_d << lz;
      ny_q <= ny_d << lz;
    end
  end

  // sqrt pipeline
  logic [63:0] sn_q [NS+1];
  logic [63:0] sr_q [NS+1];
  logic [31:0] sax_q [NS+1];
  logic [31:0] say_q [NS+1];
  always_comb begin
    sn_q[0]  = 64'(nx_q) * 64'(nx_q) + 64'(ny_q) * 64'(ny_q);
    sr_q[0]  = '0;
    sax_q[0] = nx_q;
    say_q[0] = ny_q;
  end
  for (genvar s = 0; s < NS; s++) begin : g_sqrt
    logic [63:0] n_n, r_n;
    pres_sqrt_stage u_st (
      .n_i  (sn_q[s]),
      .res_i(sr_q[s]),
      .bit_i(64'd1 << (62 - 2 * s)),
      .n_o  (n_n),
      .res_o(r_n)
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sn_q[s+1]  <= n_n;
        sr_q[s+1]  <= r_n;
        sax_q[s+1] <= sax_q[s];
        say_q[s+1] <= say_q[s];
      end
    end
  end

  // divide pipeline: dividend is a << FracBits, 48 bits, quotient fits 32 bits
  logic [31:0] len;
  assign len = sr_q[NS][31:0];
  logic [31:0] rx_q [ND+1], ry_q [ND+1], den_q [ND+1];
  logic [47:0] dvx_q [ND+1], dvy_q [ND+1];
  always_comb begin
    rx_q[0]  = '0;
    ry_q[0]  = '0;
    den_q[0] = len;
    dvx_q[0] = 48'(sax_q[NS]) << pres_pkg::FracBits;
    dvy_q[0] = 48'(say_q[NS]) << pres_pkg::FracBits;
  end
  for (genvar d = 0; d < ND; d++) begin : g_div
    logic [31:0] rxn, ryn;
    logic        qx, qy;
    pres_div_stage u_dx (
      .rem_i(rx_q[d]), .din_i(dvx_q[d][47]), .den_i(den_q[d]), .rem_o(rxn), .q_o(qx)
    );
    pres_div_stage u_dy (
      .rem_i(ry_q[d]), .din_i(dvy_q[d][47]), .den_i(den_q[d]), .rem_o(ryn), .q_o(qy)
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[d+1]  <= rxn;
        ry_q[d+1]  <= ryn;
        den_q[d+1] <= den_q[d];
        dvx_q[d+1] <= {dvx_q[d][46:0], qx};
        dvy_q[d+1] <= {dvy_q[d][46:0], qy};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[L-2:0], valid_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itm_q[0]  <= item_i;
      sx_q[0]   <= dx_i[32];
      sy_q[0]   <= dy_i[32];
      zero_q[0] <= (dx_i == '0) && (dy_i == '0);
      for (int k = 1; k < L; k++) begin
        itm_q[k]  <= itm_q[k-1];
        sx_q[k]   <= sx_q[k-1];
        sy_q[k]   <= sy_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // stage L-1: apply sign
  logic [31:0] qx_mag, qy_mag;
  assign qx_mag = dvx_q[ND][31:0];
  assign qy_mag = dvy_q[ND][31:0];
  logic signed [31:0] ux_q, uy_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q <= zero_q[L-2] ? '0 : (sx_q[L-2] ? -$signed(qx_mag) : $signed(qx_mag));
      uy_q <= zero_q[L-2] ? '0 : (sy_q[L-2] ? -$signed(qy_mag) : $signed(qy_mag));
    end
  end
  assign valid_o = vld_q[L-1];
  assign ux_o    = ux_q;
  assign uy_o    = uy_q;
  assign item_o  = itm_q[L-1];
endmodule

### design/pres_integrate.sv
`timescale 1ns / 1ps
// acceleration, velocity, position, angle and age integration pipeline
module pres_integrate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] ux_i,
  input  logic signed [31:0] uy_i,
  input  pres_pkg::item_t    item_i,
  input  logic [19:0]        dt_i,
  output logic               valid_o,
  output logic [pres_pkg::OutBytes-1:0] data_o
);
  localparam int unsigned F = pres_pkg::FracBits;
  logic [5:0] vld_q;

  // s1: products
  logic signed [63:0] rux_q, ruy_q, tux_q, tuy_q, sp_q;
  pres_pkg::item_t    i1_q, i2_q, i3_q, i4_q, i5_q;
  // s2: accel
  logic signed [31:0] acx_q, acy_q, ang2_q;
  // s3: a*dt
  logic signed [63:0] adx_q, ady_q;
  logic signed [31:0] ang3_q, ang4_q, ang5_q;
  // s4: vel
  logic signed [31:0] nvx_q, nvy_q, nvx5_q, nvy5_q;
  // s5: v*dt
  logic signed [63:0] pdx_q, pdy_q;
  logic signed [31:0] npx_q, npy_q, nvx6_q, nvy6_q, ang6_q;
  logic [30:0]        age_q;
  logic               exp_q;

  logic signed [20:0] dts;
  assign dts = $signed({1'b0, dt_i});

  function automatic logic signed [65:0] fl(input logic signed [63:0] p);
    return 66'(p >>> F);
  endfunction

  logic [31:0] nage;
  assign nage = 32'(i5_q.age_in) + 32'(dt_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rux_q <= 64'(item_i.radial_acc) * 64'(ux_i);
      ruy_q <= 64'(item_i.radial_acc) * 64'(uy_i);
      tux_q <= 64'(item_i.tangent_acc) * 64'(ux_i);
      tuy_q <= 64'(item_i.tangent_acc) * 64'(uy_i);
      sp_q  <= 64'(item_i.spin_rate) * 64'(dts);
      i1_q  <= item_i;

      acx_q  <= pres_pkg::sat32(fl(rux_q) + fl(-tuy_q));
      acy_q  <= pres_pkg::sat32(66'(i1_q.gravity_acc) + fl(ruy_q) + fl(tux_q));
      ang2_q <= pres_pkg::sat32(66'(i1_q.angle_in) + fl(sp_q));
      i2_q   <= i1_q;

      adx_q  <= 64'(acx_q) * 64'(dts);
      ady_q  <= 64'(acy_q) * 64'(dts);
      ang3_q <= ang2_q;
      i3_q   <= i2_q;

      nvx_q  <= pres_pkg::sat32(66'(i3_q.vel_x) + fl(adx_q));
      nvy_q  <= pres_pkg::sat32(66'(i3_q.vel_y) + fl(ady_q));
      ang4_q <= ang3_q;
      i4_q   <= i3_q;

      pdx_q  <= 64'(nvx_q) * 64'(dts);
      pdy_q  <= 64'(nvy_q) * 64'(dts);
      nvx5_q <= nvx_q;
      nvy5_q <= nvy_q;
      ang5_q <= ang4_q;
      i5_q   <= i4_q;

      npx_q  <= pres_pkg::sat32(66'(i5_q.pos_x) + fl(pdx_q));
      npy_q  <= pres_pkg::sat32(66'(i5_q.pos_y) + fl(pdy_q));
      nvx6_q <= nvx5_q;
      nvy6_q <= nvy5_q;
      ang6_q <= ang5_q;
      age_q  <= nage[31] ? 31'h7fffffff : nage[30:0];
      exp_q  <= (nage[31] ? 31'h7fffffff : nage[30:0]) >= i5_q.lifespan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];
  assign data_o  = {exp_q, ang6_q, age_q, nvy6_q, nvx6_q, npy_q, npx_q};
endmodule

### design/pres_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pres_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [pres_pkg::OutBytes-1:0] m_axis_tdata
);
  `ASSERT_IMPL(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPL(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
  `ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
endmodule

bind particle_radial_euler_step_core pres_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
